>>> design/tmtr_pkg.sv
// ----------------------------------------------------------------------------
// tmtr_pkg: shared types and constants of the temperature trend tracker
// field widths, stream packing and trend tracking start values
// ----------------------------------------------------------------------------
package tmtr_pkg;

    localparam int TEMP_BITS         = 12;
    localparam int DIFF_BITS         = TEMP_BITS + 1;
    localparam int GRAD_BITS         = 17;
    localparam int COUNT_BITS        = 4;
    localparam int TICK_BITS         = 32;
    localparam int LIMIT_BITS        = 8;
    localparam int WINDOW_DEPTH_DEF  = 10;
    localparam int PLATEAU_BALANCE   = 3;
    localparam int GRADIENT_SCALE    = 10;

    localparam logic [LIMIT_BITS-1:0]       SMALL_LIMIT_RESET = LIMIT_BITS'(5);
    localparam logic signed [TEMP_BITS-1:0] DOWN_MIN_START    = TEMP_BITS'(1500);
    localparam logic signed [TEMP_BITS-1:0] UP_MAX_START      = TEMP_BITS'(-500);

    // stream packing
    localparam int IN_FIELD_BITS  = TEMP_BITS + TICK_BITS;
    localparam int IN_TDATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0]  up_maximum;
        logic signed [TEMP_BITS-1:0]  down_minimum;
        logic                         plateau;
        logic [TICK_BITS-1:0]         ended_trend_ticks;
        logic                         trend_changed;
        logic                         rising_trend;
        logic [COUNT_BITS-1:0]        small_count;
        logic [COUNT_BITS-1:0]        rising_count;
        logic [COUNT_BITS-1:0]        falling_count;
        logic signed [GRAD_BITS-1:0]  gradient;
        logic signed [TEMP_BITS-1:0]  mean_temp;
    } t_result;

    localparam int OUT_FIELD_BITS = $bits(t_result);
    localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

endpackage

>>> design/tmtr_window_ram.sv
// ----------------------------------------------------------------------------
// tmtr_window_ram: window store
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tmtr_window_ram #(
    parameter int DEPTH   = 10,
    parameter int WIDTH   = 25,
    parameter int ADDR_W  = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tmtr_divider.sv
// ----------------------------------------------------------------------------
// tmtr_divider: bit-serial signed by unsigned divider
// restoring division, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module tmtr_divider #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic             r_neg;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;
    logic [NUM_W-1:0] w_mag;

    assign w_mag   = i_dividend[NUM_W-1] ? NUM_W'(-i_dividend) : NUM_W'(i_dividend);
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= w_mag;
            r_neg <= i_dividend[NUM_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? NUM_W'(-signed'(r_quo)) : signed'(r_quo);

endmodule

>>> design/temperature_trend_tracker.sv
// ----------------------------------------------------------------------------
// temperature_trend_tracker: windowed temperature mean, gradient and trend
// sample and difference window in one memory, bit-serial dividers
// ----------------------------------------------------------------------------
// One sample transaction is handled at a time. The sample and its difference
// are written to the window memory on acceptance, then the filled part of the
// window is read back one entry per cycle, then the mean and gradient come
// from two bit-serial dividers running side by side (quotients of 13 + 4 +
// clog2(WINDOW_DEPTH + 1) bits, 21 with a depth of ten), and the result is
// then loaded into the output register once that register is free. The next
// sample is taken as soon as the result is loaded into the output register,
// even if that result is still waiting.
// small_delta_limit is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this.
module temperature_trend_tracker #(
    parameter int WINDOW_DEPTH = tmtr_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmtr_pkg::LIMIT_BITS-1:0]   i_cfg_wdata,   // small_delta_limit
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // temperature [11:0], tick [43:12], zero pad above
    input  logic [tmtr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mean_temp [11:0], gradient [28:12], falling_count [32:29],
    // rising_count [36:33], small_count [40:37], rising_trend [41],
    // trend_changed [42], ended_trend_ticks [74:43], plateau [75],
    // down_minimum [87:76], up_maximum [99:88], zero pad above
    output logic [tmtr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import tmtr_pkg::*;

    localparam int AW      = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = TEMP_BITS + CNT_W;
    localparam int DSUM_W  = DIFF_BITS + CNT_W;
    localparam int DIV_W   = DSUM_W + 4;
    localparam int ENTRY_W = DIFF_BITS + TEMP_BITS;

    localparam logic signed [DIV_W-1:0] GRAD_SCALE_S = DIV_W'(GRADIENT_SCALE);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} t_state;

    t_state                       r_state;
    logic [LIMIT_BITS-1:0]        r_limit;
    logic [AW-1:0]                r_slot;
    logic [CNT_W-1:0]             r_fill;
    logic signed [TEMP_BITS-1:0]  r_prev;
    logic signed [TEMP_BITS-1:0]  r_temp;
    logic [TICK_BITS-1:0]         r_tick;
    logic                         r_dir_up;
    logic [TICK_BITS-1:0]         r_trend_start;
    logic signed [TEMP_BITS-1:0]  r_lowest;
    logic signed [TEMP_BITS-1:0]  r_highest;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_rd_vld;
    logic signed [SUM_W-1:0]      r_sum;
    logic signed [DSUM_W-1:0]     r_dsum;
    logic [CNT_W-1:0]             r_fall;
    logic [CNT_W-1:0]             r_rise;
    logic [CNT_W-1:0]             r_small;
    logic                         r_out_valid;
    t_result                      r_result;

    logic                         w_in_acc;
    logic signed [TEMP_BITS-1:0]  w_in_temp;
    logic [DIFF_BITS-1:0]         w_in_diff;
    logic                         w_rd_en;
    logic [ENTRY_W-1:0]           w_rdata;
    logic signed [DIFF_BITS-1:0]  w_rd_diff;
    logic signed [TEMP_BITS-1:0]  w_rd_temp;
    logic [DIFF_BITS-1:0]         w_rd_mag;
    logic                         w_div_start;
    logic signed [DIV_W-1:0]      w_dsum_ext;
    logic signed [DIV_W-1:0]      w_grad_num;
    logic                         w_mean_done;
    logic                         w_grad_done;
    logic signed [DIV_W-1:0]      w_mean_q;
    logic signed [DIV_W-1:0]      w_grad_q;
    logic                         w_out_free;
    logic                         w_load;
    logic                         w_fall_only;
    logic                         w_rise_only;
    logic [CNT_W-1:0]             w_bal;
    logic                         w_plateau;
    logic                         w_changed;
    logic                         n_dir_up;
    logic signed [TEMP_BITS-1:0]  n_lowest;
    logic signed [TEMP_BITS-1:0]  n_highest;
    logic [TICK_BITS-1:0]         n_trend_start;
    logic [TICK_BITS-1:0]         w_ended;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_temp     = s_axis_tdata[TEMP_BITS-1:0];
    // first sample of all has no predecessor
    assign w_in_diff     = (r_fill != '0) ?
                           DIFF_BITS'(w_in_temp) - DIFF_BITS'(r_prev) : '0;

    assign w_rd_en   = (r_state == S_SCAN) && (r_idx < r_fill);
    assign w_rd_diff = w_rdata[ENTRY_W-1:TEMP_BITS];
    assign w_rd_temp = w_rdata[TEMP_BITS-1:0];
    assign w_rd_mag  = w_rd_diff[DIFF_BITS-1] ? DIFF_BITS'(-w_rd_diff)
                                              : DIFF_BITS'(w_rd_diff);

    tmtr_window_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_slot),
        .i_wdata ({w_in_diff, w_in_temp}),
        .i_re    (w_rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // walk done once nothing is issued and nothing is in flight
    assign w_div_start = (r_state == S_SCAN) && !w_rd_en && !r_rd_vld;
    assign w_dsum_ext  = DIV_W'(r_dsum);
    assign w_grad_num  = w_dsum_ext * GRAD_SCALE_S;

    tmtr_divider #(
        .NUM_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (DIV_W'(r_sum)),
        .i_divisor  (r_fill),
        .o_done     (w_mean_done),
        .o_quotient (w_mean_q)
    );

    tmtr_divider #(
        .NUM_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_grad_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_grad_num),
        .i_divisor  (r_fill),
        .o_done     (w_grad_done),
        .o_quotient (w_grad_q)
    );

    // trend decision
    assign w_fall_only = (r_fall != '0) && (r_rise == '0);
    assign w_rise_only = (r_rise != '0) && (r_fall == '0);
    assign w_bal       = (r_fall >= r_rise) ? r_fall - r_rise : r_rise - r_fall;
    assign w_plateau   = !w_fall_only && !w_rise_only
                         && (r_small == CNT_W'(WINDOW_DEPTH))
                         && (w_bal < CNT_W'(PLATEAU_BALANCE));
    assign w_changed   = (w_fall_only && r_dir_up) || (w_rise_only && !r_dir_up);
    assign w_ended     = w_changed ? r_tick - r_trend_start : '0;
    assign n_trend_start = w_changed ? r_tick : r_trend_start;

    always_comb begin
        n_dir_up  = r_dir_up;
        n_lowest  = r_lowest;
        n_highest = r_highest;
        priority if (w_fall_only) begin
            n_dir_up = 1'b0;
            if (r_dir_up) begin
                n_lowest = DOWN_MIN_START;
            end else if (r_temp < r_lowest) begin
                n_lowest = r_temp;
            end
        end else if (w_rise_only) begin
            n_dir_up = 1'b1;
            if (!r_dir_up) begin
                n_highest = UP_MAX_START;
            end else if (r_temp > r_highest) begin
                n_highest = r_temp;
            end
        end else begin
            n_dir_up = r_dir_up;
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_load     = (r_state == S_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_limit       <= SMALL_LIMIT_RESET;
            r_slot        <= '0;
            r_fill        <= '0;
            r_prev        <= '0;
            r_dir_up      <= 1'b0;
            r_trend_start <= '0;
            r_lowest      <= DOWN_MIN_START;
            r_highest     <= UP_MAX_START;
            r_idx         <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_rd_vld <= w_rd_en;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_slot  <= (r_slot == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                    : r_slot + AW'(1);
                        if (r_fill != CNT_W'(WINDOW_DEPTH)) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                        r_prev  <= w_in_temp;
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_mean_done && w_grad_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_dir_up      <= n_dir_up;
                        r_trend_start <= n_trend_start;
                        r_lowest      <= n_lowest;
                        r_highest     <= n_highest;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_temp  <= w_in_temp;
            r_tick  <= s_axis_tdata[TEMP_BITS +: TICK_BITS];
            r_sum   <= '0;
            r_dsum  <= '0;
            r_fall  <= '0;
            r_rise  <= '0;
            r_small <= '0;
        end else if (r_rd_vld) begin
            r_sum   <= r_sum + SUM_W'(w_rd_temp);
            r_dsum  <= r_dsum + DSUM_W'(w_rd_diff);
            r_fall  <= r_fall + CNT_W'(w_rd_diff < 0);
            r_rise  <= r_rise + CNT_W'(w_rd_diff > 0);
            r_small <= r_small + CNT_W'(w_rd_mag < DIFF_BITS'(r_limit));
        end
        if (w_load) begin
            r_result.mean_temp         <= TEMP_BITS'(w_mean_q);
            r_result.gradient          <= GRAD_BITS'(w_grad_q);
            r_result.falling_count     <= COUNT_BITS'(r_fall);
            r_result.rising_count      <= COUNT_BITS'(r_rise);
            r_result.small_count       <= COUNT_BITS'(r_small);
            r_result.rising_trend      <= n_dir_up;
            r_result.trend_changed     <= w_changed;
            r_result.ended_trend_ticks <= w_ended;
            r_result.plateau           <= w_plateau;
            r_result.down_minimum      <= n_lowest;
            r_result.up_maximum        <= n_highest;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_result);

    ap_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    ap_div_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mean_done == w_grad_done)
        else $error("dividers out of step");

    ap_change_flips : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_changed) |=> (r_dir_up != $past(r_dir_up)))
        else $error("trend change without direction flip");

    ap_no_plateau_on_change : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_result.plateau && r_result.trend_changed))
        else $error("plateau flagged on a trend change");

    ap_accept_starts_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SCAN) && (r_fill != '0))
        else $error("accepted sample did not start a window walk");

endmodule
